@@ design/dlf_pkg.sv @@
// ----------------------------------------------------------------------------
// dlf_pkg - shared types and arithmetic for the dense layer forward block
// Field widths, command codes, the control structs passed between the
// sequencer and its datapath units, and the saturating arithmetic.
// ----------------------------------------------------------------------------
package dlf_pkg;

   localparam int VALUE_W         = 16;  // Q8.8 weight, bias, activation
   localparam int INDEX_W         = 6;   // in_index, out_index, result_index
   localparam int SIZE_W          = 7;   // out_size register
   localparam int PROD_W          = 32;  // Q16.16 product
   localparam int ACC_W           = 40;  // accumulator
   localparam int RESULT_W        = 32;  // Q16.16 result
   localparam int INDEX_LIMIT     = 64;  // rows addressable by in_index
   localparam int MAX_INPUTS_DEF  = 64;
   localparam int MAX_OUTPUTS_DEF = 64;

   localparam logic [SIZE_W-1:0] OUT_SIZE_RESET = 7'd64;

   typedef enum logic [1:0] {
      CMD_WEIGHT = 2'd0,
      CMD_BIAS   = 2'd1,
      CMD_ACT    = 2'd2
   } cmd_type;

   // sequencer -> MAC unit
   typedef struct packed {
      logic                       start;
      logic signed [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]         row;
      logic [INDEX_W-1:0]         last_idx;
   } mac_cmd_type;

   // sequencer -> result unit
   typedef struct packed {
      logic               start;
      logic [INDEX_W-1:0] last_idx;
   } emit_cmd_type;

   // MAC unit -> accumulator memory write port
   typedef struct packed {
      logic                     en;
      logic [INDEX_W-1:0]       addr;
      logic signed [ACC_W-1:0]  data;
   } acc_wr_type;

   typedef struct packed {
      logic signed [RESULT_W-1:0] value;
      logic                       sat;
   } result_type;

   // acc + prod, clipped to the signed ACC_W range
   function automatic logic signed [ACC_W-1:0] acc_add_sat(
      input logic signed [ACC_W-1:0]  acc,
      input logic signed [PROD_W-1:0] prod
   );
      logic signed [ACC_W:0] sum;
      logic signed [ACC_W-1:0] res;
      sum = {acc[ACC_W-1], acc} + {{(ACC_W+1-PROD_W){prod[PROD_W-1]}}, prod};
      if (sum[ACC_W] != sum[ACC_W-1]) begin
         res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         res = sum[ACC_W-1:0];
      end
      return res;
   endfunction

   // acc + (bias << 8), clipped to the signed RESULT_W range
   function automatic result_type add_bias_clip(
      input logic signed [ACC_W-1:0]   acc,
      input logic signed [VALUE_W-1:0] bias
   );
      logic signed [ACC_W:0] sum;
      result_type res;
      sum = {acc[ACC_W-1], acc}
          + {{(ACC_W+1-VALUE_W-8){bias[VALUE_W-1]}}, bias, 8'd0};
      if ((sum[ACC_W:RESULT_W-1] == '0) || (sum[ACC_W:RESULT_W-1] == '1)) begin
         res.value = sum[RESULT_W-1:0];
         res.sat   = 1'b0;
      end else begin
         res.value = sum[ACC_W] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                : {1'b0, {(RESULT_W-1){1'b1}}};
         res.sat   = 1'b1;
      end
      return res;
   endfunction

endpackage

@@ design/dlf_ram.sv @@
// ----------------------------------------------------------------------------
// dlf_ram - generic simple dual-port RAM
// One write port, one read port, read data registered; the read register
// holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module dlf_ram #(
   parameter  int WIDTH  = 16,
   parameter  int DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/dlf_mac.sv @@
// ----------------------------------------------------------------------------
// dlf_mac - multiply-accumulate sweep over one weight row
// Walks the outputs in use one per cycle: read weight and accumulator,
// multiply, then add with saturation and write the accumulator back.
// ----------------------------------------------------------------------------
module dlf_mac #(
   parameter int AW_IN  = 6,
   parameter int AW_OUT = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  dlf_pkg::mac_cmd_type                cmd,
   output logic                                busy,
   output logic                                rd_en,
   output logic [AW_IN+AW_OUT-1:0]             w_addr,
   output logic [AW_OUT-1:0]                   acc_addr,
   input  logic signed [dlf_pkg::VALUE_W-1:0]  w_data,
   input  logic signed [dlf_pkg::ACC_W-1:0]    acc_data,
   output dlf_pkg::acc_wr_type                 acc_wr
);

   localparam int IW = dlf_pkg::INDEX_W;

   logic                              issue_ff;
   logic [AW_OUT-1:0]                 idx_ff;
   logic [AW_OUT-1:0]                 last_ff;
   logic [AW_IN-1:0]                  row_ff;
   logic signed [dlf_pkg::VALUE_W-1:0] value_ff;
   logic                              s1_vld_ff;
   logic [AW_OUT-1:0]                 s1_idx_ff;
   logic                              s2_vld_ff;
   logic [AW_OUT-1:0]                 s2_idx_ff;
   logic signed [dlf_pkg::PROD_W-1:0] prod_ff;
   logic signed [dlf_pkg::ACC_W-1:0]  acc_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff  <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            issue_ff <= 1'b1;
         end else if (issue_ff && (idx_ff == last_ff)) begin
            issue_ff <= 1'b0;
         end
         s1_vld_ff <= issue_ff;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         idx_ff   <= '0;
         last_ff  <= cmd.last_idx[AW_OUT-1:0];
         row_ff   <= cmd.row[AW_IN-1:0];
         value_ff <= cmd.value;
      end else if (issue_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
      s1_idx_ff <= idx_ff;
      s2_idx_ff <= s1_idx_ff;
      prod_ff   <= value_ff * w_data;   // Q8.8 x Q8.8 -> Q16.16
      acc_q_ff  <= acc_data;
   end

   assign busy     = issue_ff | s1_vld_ff | s2_vld_ff;
   assign rd_en    = issue_ff;
   assign w_addr   = {row_ff, idx_ff};
   assign acc_addr = idx_ff;

   assign acc_wr.en   = s2_vld_ff;
   assign acc_wr.addr = IW'(s2_idx_ff);
   assign acc_wr.data = dlf_pkg::acc_add_sat(acc_q_ff, prod_ff);

endmodule

@@ design/dlf_emit.sv @@
// ----------------------------------------------------------------------------
// dlf_emit - result sweep at row end
// Reads accumulator and bias per output, adds and clips, and feeds the
// result register. One read is kept in flight; the RAM output register
// holds it while the result register is blocked.
// ----------------------------------------------------------------------------
module dlf_emit #(
   parameter int AW_OUT = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dlf_pkg::emit_cmd_type                cmd,
   output logic                                 busy,
   output logic                                 rd_en,
   output logic [AW_OUT-1:0]                    rd_addr,
   input  logic signed [dlf_pkg::ACC_W-1:0]     acc_data,
   input  logic signed [dlf_pkg::VALUE_W-1:0]   bias_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dlf_pkg::INDEX_W-1:0]          rsp_result_index,
   output logic signed [dlf_pkg::RESULT_W-1:0]  rsp_result_value,
   output logic                                 rsp_result_last,
   output logic                                 rsp_saturated
);

   localparam int IW = dlf_pkg::INDEX_W;

   logic                                busy_ff;
   logic                                more_ff;
   logic [AW_OUT-1:0]                   rd_idx_ff;
   logic [AW_OUT-1:0]                   last_ff;
   logic                                pend_ff;
   logic [AW_OUT-1:0]                   pend_idx_ff;
   logic                                rsp_valid_ff;
   logic [IW-1:0]                       rsp_index_ff;
   logic signed [dlf_pkg::RESULT_W-1:0] rsp_value_ff;
   logic                                rsp_last_ff;
   logic                                rsp_sat_ff;

   logic                 load;
   logic                 issue;
   logic                 pend_last;
   dlf_pkg::result_type  res;

   assign load      = pend_ff && (!rsp_valid_ff || rsp_ready);
   assign issue     = more_ff && (!pend_ff || load);
   assign pend_last = (pend_idx_ff == last_ff);
   assign res       = dlf_pkg::add_bias_clip(acc_data, bias_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         more_ff      <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.start) begin
            busy_ff <= 1'b1;
            more_ff <= 1'b1;
         end else begin
            if (issue && (rd_idx_ff == last_ff)) begin
               more_ff <= 1'b0;
            end
            if (load && pend_last) begin
               busy_ff <= 1'b0;
            end
         end
         pend_ff <= issue | (pend_ff & ~load);
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rd_idx_ff <= '0;
         last_ff   <= cmd.last_idx[AW_OUT-1:0];
      end else if (issue) begin
         rd_idx_ff <= rd_idx_ff + 1'b1;
      end
      if (issue) begin
         pend_idx_ff <= rd_idx_ff;
      end
      if (load) begin
         rsp_index_ff <= IW'(pend_idx_ff);
         rsp_value_ff <= res.value;
         rsp_last_ff  <= pend_last;
         rsp_sat_ff   <= res.sat;
      end
   end

   assign busy             = busy_ff;
   assign rd_en            = issue;
   assign rd_addr          = rd_idx_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_result_last  = rsp_last_ff;
   assign rsp_saturated    = rsp_sat_ff;

endmodule

@@ design/dense_layer_forward.sv @@
// ----------------------------------------------------------------------------
// dense_layer_forward - fully connected layer, one input row at a time
// Loads a Q8.8 weight matrix and bias vector, accumulates activation times
// weight row per output, and emits saturated Q16.16 sums at row end.
// ----------------------------------------------------------------------------
// Usage and timing: a weight or bias load is written on the transfer. An
// activation with an in-range in_index sweeps the outputs in use (n =
// out_size, clamped to 1..MAX_OUTPUTS) one per cycle through the
// accumulator memory, which has a single read and a single write port; the
// block is ready again once that sweep has drained. An activation marked
// row_last then streams n results, one per cycle while rsp_ready stays high,
// after the accumulator and bias reads, and clears all accumulators. The
// block takes one item at a time; the last result may still sit in the
// output register while the next item is accepted. Weights and biases hold garbage until loaded.
// ----------------------------------------------------------------------------
module dense_layer_forward #(
   parameter int MAX_INPUTS  = dlf_pkg::MAX_INPUTS_DEF,
   parameter int MAX_OUTPUTS = dlf_pkg::MAX_OUTPUTS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_wr_en,
   input  logic [dlf_pkg::SIZE_W-1:0]           csr_wr_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_cmd,
   input  logic [dlf_pkg::INDEX_W-1:0]          req_in_index,
   input  logic [dlf_pkg::INDEX_W-1:0]          req_out_index,
   input  logic signed [dlf_pkg::VALUE_W-1:0]   req_value,
   input  logic                                 req_row_last,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dlf_pkg::INDEX_W-1:0]          rsp_result_index,
   output logic signed [dlf_pkg::RESULT_W-1:0]  rsp_result_value,
   output logic                                 rsp_result_last,
   output logic                                 rsp_saturated
);

   localparam int IW     = dlf_pkg::INDEX_W;
   localparam int SZW    = dlf_pkg::SIZE_W;
   localparam int VW     = dlf_pkg::VALUE_W;
   localparam int AW     = dlf_pkg::ACC_W;
   // only rows reachable by in_index get storage
   localparam int ROWS   = (MAX_INPUTS < dlf_pkg::INDEX_LIMIT) ? MAX_INPUTS
                                                              : dlf_pkg::INDEX_LIMIT;
   localparam int AW_IN  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int AW_OUT = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
   localparam int WDEPTH = 1 << (AW_IN + AW_OUT);

   localparam logic [SZW-1:0] MAX_OUT_SIZE = SZW'(MAX_OUTPUTS);
   localparam logic [SZW-1:0] MAX_OUT_LAST = SZW'(MAX_OUTPUTS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_EMIT
   } state_type;

   state_type state_ff;
   logic      row_last_ff;

   logic [SZW-1:0]           size_ff;
   logic [SZW-1:0]           n_last;          // index of last output in use
   logic [MAX_OUTPUTS-1:0]   acc_vld_ff;      // accumulator holds a written sum
   logic                     vld_rd_ff;       // valid bit of the entry last read

   logic accept;
   logic in_ok;
   logic out_ok;
   logic w_wr_en;
   logic b_wr_en;
   logic act_go;
   logic emit_done;

   dlf_pkg::mac_cmd_type  mac_cmd;
   dlf_pkg::emit_cmd_type emit_cmd;
   dlf_pkg::acc_wr_type   acc_wr;

   logic                        mac_busy;
   logic                        mac_rd_en;
   logic [AW_IN+AW_OUT-1:0]     mac_w_addr;
   logic [AW_OUT-1:0]           mac_acc_addr;
   logic                        emit_busy;
   logic                        emit_rd_en;
   logic [AW_OUT-1:0]           emit_addr;

   logic                        acc_rd_en;
   logic [AW_OUT-1:0]           acc_raddr;
   logic [AW-1:0]               acc_rdata_raw;
   logic signed [AW-1:0]        acc_rdata;
   logic [VW-1:0]               w_rdata_raw;
   logic [VW-1:0]               b_rdata_raw;

   // ---------------------------------------------------------------------
   // Configuration: output count, clamped when used
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= dlf_pkg::OUT_SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   always_comb begin
      if (size_ff == '0) begin
         n_last = '0;
      end else if (size_ff > MAX_OUT_SIZE) begin
         n_last = MAX_OUT_LAST;
      end else begin
         n_last = size_ff - 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Request decode. Loads write straight into memory on the transfer;
   // out-of-range loads and unknown commands are dropped.
   // ---------------------------------------------------------------------
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_ok     = 32'(req_in_index) < 32'(MAX_INPUTS);
   assign out_ok    = 32'(req_out_index) < 32'(MAX_OUTPUTS);

   always_comb begin
      w_wr_en = 1'b0;
      b_wr_en = 1'b0;
      act_go  = 1'b0;
      case (req_cmd)
         dlf_pkg::CMD_WEIGHT: w_wr_en = accept && in_ok && out_ok;
         dlf_pkg::CMD_BIAS:   b_wr_en = accept && out_ok;
         dlf_pkg::CMD_ACT:    act_go  = accept;
         default:             ;
      endcase
   end

   // an activation beyond the stored rows adds nothing but still ends a row
   assign mac_cmd.start    = act_go && in_ok;
   assign mac_cmd.value    = req_value;
   assign mac_cmd.row      = req_in_index;
   assign mac_cmd.last_idx = IW'(n_last);

   assign emit_cmd.start    = (act_go && !in_ok && req_row_last)
                           || ((state_ff == ST_MAC) && !mac_busy && row_last_ff);
   assign emit_cmd.last_idx = IW'(n_last);

   assign emit_done = (state_ff == ST_EMIT) && !emit_busy;

   // ---------------------------------------------------------------------
   // Sequencer: one item in flight; MAC sweep fully drains before the
   // result sweep reads the accumulators.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         row_last_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (act_go) begin
                  row_last_ff <= req_row_last;
                  if (in_ok) begin
                     state_ff <= ST_MAC;
                  end else if (req_row_last) begin
                     state_ff <= ST_EMIT;
                  end
               end
            end
            ST_MAC: begin
               if (!mac_busy) begin
                  state_ff <= row_last_ff ? ST_EMIT : ST_IDLE;
               end
            end
            ST_EMIT: begin
               if (!emit_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Accumulator valid bits: an entry not written since the last row end
   // reads as zero. All clear at once when the result sweep finishes.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_vld_ff <= '0;
      end else if (emit_done) begin
         acc_vld_ff <= '0;
      end else if (acc_wr.en) begin
         acc_vld_ff[acc_wr.addr[AW_OUT-1:0]] <= 1'b1;
      end
   end

   // follows the RAM read register: updates only on a read
   always_ff @(posedge clock) begin
      if (acc_rd_en) begin
         vld_rd_ff <= acc_vld_ff[acc_raddr];
      end
   end

   assign acc_rd_en = mac_rd_en | emit_rd_en;
   assign acc_raddr = mac_rd_en ? mac_acc_addr : emit_addr;
   assign acc_rdata = vld_rd_ff ? $signed(acc_rdata_raw) : '0;

   // ---------------------------------------------------------------------
   // Memories
   // ---------------------------------------------------------------------
   dlf_ram #(
      .WIDTH (VW),
      .DEPTH (WDEPTH)
   ) u_weight_ram (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr ({req_in_index[AW_IN-1:0], req_out_index[AW_OUT-1:0]}),
      .wr_data (req_value),
      .rd_en   (mac_rd_en),
      .rd_addr (mac_w_addr),
      .rd_data (w_rdata_raw)
   );

   dlf_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_OUTPUTS)
   ) u_bias_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (req_out_index[AW_OUT-1:0]),
      .wr_data (req_value),
      .rd_en   (emit_rd_en),
      .rd_addr (emit_addr),
      .rd_data (b_rdata_raw)
   );

   dlf_ram #(
      .WIDTH (AW),
      .DEPTH (MAX_OUTPUTS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (acc_wr.en),
      .wr_addr (acc_wr.addr[AW_OUT-1:0]),
      .wr_data (acc_wr.data),
      .rd_en   (acc_rd_en),
      .rd_addr (acc_raddr),
      .rd_data (acc_rdata_raw)
   );

   // ---------------------------------------------------------------------
   // Datapath units
   // ---------------------------------------------------------------------
   dlf_mac #(
      .AW_IN  (AW_IN),
      .AW_OUT (AW_OUT)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .cmd      (mac_cmd),
      .busy     (mac_busy),
      .rd_en    (mac_rd_en),
      .w_addr   (mac_w_addr),
      .acc_addr (mac_acc_addr),
      .w_data   ($signed(w_rdata_raw)),
      .acc_data (acc_rdata),
      .acc_wr   (acc_wr)
   );

   dlf_emit #(
      .AW_OUT (AW_OUT)
   ) u_emit (
      .clock            (clock),
      .reset            (reset),
      .cmd              (emit_cmd),
      .busy             (emit_busy),
      .rd_en            (emit_rd_en),
      .rd_addr          (emit_addr),
      .acc_data         (acc_rdata),
      .bias_data        ($signed(b_rdata_raw)),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_index (rsp_result_index),
      .rsp_result_value (rsp_result_value),
      .rsp_result_last  (rsp_result_last),
      .rsp_saturated    (rsp_saturated)
   );

endmodule
